FILE: hdl/sequential_halving_arm_selector_core_assert.svh
// Assertion macros for the sequential halving arm selector.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef SEQUENTIAL_HALVING_ARM_SELECTOR_CORE_ASSERT_SVH
`define SEQUENTIAL_HALVING_ARM_SELECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define SHA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha assertion failed");

// next-cycle implication
`define SHA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha assertion failed");

`endif

FILE: hdl/sha_pkg.sv
// Shared types, constants and helpers of the sequential halving arm selector.
// No dependencies.
package sha_pkg;

  localparam int MAX_ARMS = 64;
  localparam int ADDR_W   = $clog2(MAX_ARMS);
  localparam int SCORE_W  = 16;
  localparam int LABEL_W  = 6;
  localparam int CNT_W    = 7;
  localparam int BUDGET_W = 20;
  localparam int ROUND_W  = 6;
  localparam int DIVR_W   = 3;
  localparam int CFG_W    = 20;

  localparam logic [ROUND_W-1:0] ROUND_MAX = '1;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SELECT = 2'd1,
    REQ_REPORT = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic {
    CFG_ARM_COUNT    = 1'b0,
    CFG_TOTAL_BUDGET = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SORT_RDKEY,
    ST_SORT_KEY,
    ST_SORT_SHIFT,
    ST_SORT_PLACE,
    ST_SEL_RD,
    ST_SEL_OUT,
    ST_REP_CHK
  } state_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [LABEL_W-1:0] label;
  } arm_entry_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    arm_entry_t         data;
  } mem_wr_t;

  // arm count clamped to [2, MAX_ARMS]
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (r < CNT_W'(2)) r = CNT_W'(2);
    if (r > CNT_W'(MAX_ARMS)) r = CNT_W'(MAX_ARMS);
    return r;
  endfunction

  // ceil(log2 n) for n >= 2
  function automatic logic [DIVR_W-1:0] round_total(input logic [CNT_W-1:0] n);
    logic [DIVR_W-1:0] r;
    r = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if ((CNT_W+1)'(1 << k) < {1'b0, n}) r = r + DIVR_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: hdl/sequential_halving_arm_selector_core.sv
// Sequential halving arm selector: one transaction in flight, result strobed on out_valid.
// Load and a select that opens a round both run the divider; such a select then sorts the
// active prefix by insertion and halves it. Sort and search are bound by the single read
// port of the arm table. Receiver cannot stall; busy is high while working. Synchronous
// active-low reset clears control state; table is not cleared.
module sequential_halving_arm_selector_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic [sha_pkg::LABEL_W-1:0]   in_arm_id,
  input  logic [sha_pkg::SCORE_W-1:0]   in_reward,
  output logic                          out_valid,
  output logic [sha_pkg::LABEL_W-1:0]   out_chosen_arm,
  output logic [sha_pkg::LABEL_W-1:0]   out_best_arm,
  output logic [sha_pkg::ROUND_W-1:0]   out_round_number,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sha_pkg::CFG_W-1:0]     cfg_wdata
);
  import sha_pkg::*;

  `include "sequential_halving_arm_selector_core_assert.svh"

  state_t              state_r, state_nxt;
  req_t                req_r, req_nxt;
  logic [LABEL_W-1:0]  id_r, id_nxt;
  logic [SCORE_W-1:0]  rew_r, rew_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [CNT_W-1:0]    active_r, active_nxt;
  logic [ROUND_W-1:0]  rounds_r, rounds_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;     // pick count modulo active range
  logic [ADDR_W-1:0]   si_r, si_nxt;       // sort outer index
  logic [ADDR_W-1:0]   sj_r, sj_nxt;       // sort insert position
  logic [ADDR_W-1:0]   k_r, k_nxt;         // report search position
  arm_entry_t          key_r, key_nxt;
  logic [LABEL_W-1:0]  chosen_r, chosen_nxt;
  logic                out_valid_r, fire;
  logic [CNT_W-1:0]    arm_count_r;
  logic [BUDGET_W-1:0] total_budget_r;
  arm_entry_t          sh0_r, sh1_r;       // shadow copies of positions 0 and 1

  mem_wr_t             wr;
  logic [ADDR_W-1:0]   rd_addr;
  arm_entry_t          rd_data;

  logic                div_start, div_done;
  logic [BUDGET_W-1:0] div_q, round_budget;
  logic [CNT_W-1:0]    n_eff;

  sha_arm_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign n_eff = eff_count(arm_count_r);

  sha_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_budget_r),
    .divisor  (round_total(n_eff)),
    .done     (div_done),
    .quotient (div_q)
  );

  // per-round budget, floored at one
  assign round_budget = (div_q == '0) ? BUDGET_W'(1) : div_q;

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    id_nxt     = id_r;
    rew_nxt    = rew_r;
    budget_nxt = budget_r;
    active_nxt = active_r;
    rounds_nxt = rounds_r;
    idx_nxt    = idx_r;
    si_nxt     = si_r;
    sj_nxt     = sj_r;
    k_nxt      = k_r;
    key_nxt    = key_r;
    chosen_nxt = chosen_r;
    fire       = 1'b0;
    div_start  = 1'b0;
    wr         = '0;
    rd_addr    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt    = req_t'(in_req_type);
          id_nxt     = in_arm_id;
          rew_nxt    = in_reward;
          chosen_nxt = '0;
          unique case (req_t'(in_req_type))
            REQ_LOAD: begin
              wr.en         = 1'b1;
              wr.addr       = in_arm_id;
              wr.data.score = in_reward;
              wr.data.label = in_arm_id;
              div_start     = 1'b1;
              state_nxt     = ST_DIV;
            end
            REQ_SELECT: begin
              if (budget_r == '0) begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end else begin
                state_nxt = ST_SEL_RD;
              end
            end
            REQ_REPORT: begin
              rd_addr   = '0;
              k_nxt     = '0;
              state_nxt = ST_REP_CHK;
            end
            default: begin
              fire = 1'b1;
            end
          endcase
        end
      end

      ST_DIV: begin
        if (div_done) begin
          budget_nxt = round_budget;
          idx_nxt    = '0;
          if (req_r == REQ_LOAD) begin
            active_nxt = n_eff;
            rounds_nxt = '0;
            fire       = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            // new round: sort active prefix, then halve it
            if (rounds_r != ROUND_MAX) rounds_nxt = rounds_r + ROUND_W'(1);
            si_nxt = ADDR_W'(1);
            if (active_r > CNT_W'(1)) begin
              state_nxt = ST_SORT_RDKEY;
            end else begin
              state_nxt = ST_SEL_RD;
            end
          end
        end
      end

      ST_SORT_RDKEY: begin
        rd_addr   = si_r;
        state_nxt = ST_SORT_KEY;
      end

      ST_SORT_KEY: begin
        key_nxt   = rd_data;
        sj_nxt    = si_r;
        rd_addr   = si_r - ADDR_W'(1);
        state_nxt = ST_SORT_SHIFT;
      end

      ST_SORT_SHIFT: begin
        // rd_data holds position sj-1
        if (rd_data.score < key_r.score) begin
          wr.en   = 1'b1;
          wr.addr = sj_r;
          wr.data = rd_data;
          sj_nxt  = sj_r - ADDR_W'(1);
          if (sj_r == ADDR_W'(1)) begin
            state_nxt = ST_SORT_PLACE;
          end else begin
            rd_addr = sj_r - ADDR_W'(2);
          end
        end else begin
          state_nxt = ST_SORT_PLACE;
        end
      end

      ST_SORT_PLACE: begin
        wr.en   = 1'b1;
        wr.addr = sj_r;
        wr.data = key_r;
        si_nxt  = si_r + ADDR_W'(1);
        if ({1'b0, si_r} + CNT_W'(1) < active_r) begin
          state_nxt = ST_SORT_RDKEY;
        end else begin
          active_nxt = CNT_W'(({1'b0, active_r} + (CNT_W+1)'(1)) >> 1);
          state_nxt  = ST_SEL_RD;
        end
      end

      ST_SEL_RD: begin
        rd_addr   = idx_r;
        state_nxt = ST_SEL_OUT;
      end

      ST_SEL_OUT: begin
        chosen_nxt = rd_data.label;
        budget_nxt = budget_r - BUDGET_W'(1);
        if ({1'b0, idx_r} + CNT_W'(1) == active_r) idx_nxt = '0;
        else idx_nxt = idx_r + ADDR_W'(1);
        fire       = 1'b1;
        state_nxt  = ST_IDLE;
      end

      ST_REP_CHK: begin
        // rd_data holds position k
        if (rd_data.label == id_r) begin
          wr.en         = 1'b1;
          wr.addr       = k_r;
          wr.data.score = rew_r;
          wr.data.label = rd_data.label;
          fire          = 1'b1;
          state_nxt     = ST_IDLE;
        end else if ({1'b0, k_r} + CNT_W'(1) < active_r) begin
          rd_addr = k_r + ADDR_W'(1);
          k_nxt   = k_r + ADDR_W'(1);
        end else begin
          fire      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      budget_r       <= '0;
      active_r       <= CNT_W'(8);
      rounds_r       <= '0;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
      arm_count_r    <= CNT_W'(8);
      total_budget_r <= BUDGET_W'(1000);
    end else begin
      state_r     <= state_nxt;
      budget_r    <= budget_nxt;
      active_r    <= active_nxt;
      rounds_r    <= rounds_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= fire;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ARM_COUNT:    arm_count_r    <= cfg_wdata[CNT_W-1:0];
          CFG_TOTAL_BUDGET: total_budget_r <= cfg_wdata[BUDGET_W-1:0];
          default: ;
        endcase
      end
    end
    req_r    <= req_nxt;
    id_r     <= id_nxt;
    rew_r    <= rew_nxt;
    si_r     <= si_nxt;
    sj_r     <= sj_nxt;
    k_r      <= k_nxt;
    key_r    <= key_nxt;
    chosen_r <= chosen_nxt;
    // keep positions 0 and 1 mirrored for the recommendation
    if (wr.en && wr.addr == ADDR_W'(0)) sh0_r <= wr.data;
    if (wr.en && wr.addr == ADDR_W'(1)) sh1_r <= wr.data;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_chosen_arm   = chosen_r;
  assign out_best_arm     = (sh0_r.score > sh1_r.score) ? sh0_r.label : sh1_r.label;
  assign out_round_number = rounds_r;

  `SHA_ASSERT_IMP(a_result_when_idle, out_valid, !busy)
  `SHA_ASSERT_NEXT(a_accept_goes_busy, start && !busy && (in_req_type != REQ_NOP), busy)
  `SHA_ASSERT_IMP(a_active_in_range, 1'b1, (active_r >= CNT_W'(1)) && (active_r <= CNT_W'(MAX_ARMS)))
  `SHA_ASSERT_IMP(a_pick_in_range, 1'b1, {1'b0, idx_r} < active_r)

endmodule

FILE: hdl/sha_arm_ram.sv
// Arm table: score and label per position, one write and one read port.
// Depends on sha_pkg.
module sha_arm_ram (
  input  logic                      clk,
  input  sha_pkg::mem_wr_t          wr,
  input  logic [sha_pkg::ADDR_W-1:0] rd_addr,
  output sha_pkg::arm_entry_t       rd_data
);
  import sha_pkg::*;

  arm_entry_t mem [MAX_ARMS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/sha_divider.sv
// Serial restoring divider, one quotient bit per cycle: budget / round count.
// Depends on sha_pkg.
module sha_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sha_pkg::BUDGET_W-1:0] dividend,
  input  logic [sha_pkg::DIVR_W-1:0]   divisor,
  output logic                         done,
  output logic [sha_pkg::BUDGET_W-1:0] quotient
);
  import sha_pkg::*;

  localparam int STEP_W = $clog2(BUDGET_W + 1);

  logic [BUDGET_W-1:0] q_r, q_nxt;
  logic [DIVR_W-1:0]   rem_r, rem_nxt;
  logic [DIVR_W-1:0]   dvs_r;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [DIVR_W:0]     trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[BUDGET_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIVR_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[BUDGET_W-2:0], 1'b1};
      end else begin
        rem_nxt = DIVR_W'(trial);
        q_nxt   = {q_r[BUDGET_W-2:0], 1'b0};
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(BUDGET_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: tb/tb_sequential_halving_arm_selector_core.sv
// Self-checking testbench for sequential_halving_arm_selector_core.
// Depends on sha_pkg and the core RTL; holds its own halving-table predictor.
module tb_sequential_halving_arm_selector_core;
  import sha_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_req_type;
  logic [LABEL_W-1:0]   in_arm_id;
  logic [SCORE_W-1:0]   in_reward;
  logic                 out_valid;
  logic [LABEL_W-1:0]   out_chosen_arm;
  logic [LABEL_W-1:0]   out_best_arm;
  logic [ROUND_W-1:0]   out_round_number;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  sequential_halving_arm_selector_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_arm_id        (in_arm_id),
    .in_reward        (in_reward),
    .out_valid        (out_valid),
    .out_chosen_arm   (out_chosen_arm),
    .out_best_arm     (out_best_arm),
    .out_round_number (out_round_number),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 10-unit clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one expected result transaction
  typedef struct {
    logic [LABEL_W-1:0] chosen;
    logic [LABEL_W-1:0] best;
    logic [ROUND_W-1:0] rounds;
    bit                 best_known;  // false while entry 0 or 1 is still unwritten
  } arm_result_t;

  typedef struct {
    req_t               req;
    logic [LABEL_W-1:0] id;
    logic [SCORE_W-1:0] rew;
    bit                 typed;       // use the typed-in expectation below
    logic [LABEL_W-1:0] chosen;
    logic [LABEL_W-1:0] best;
    logic [ROUND_W-1:0] rounds;
  } dir_row_t;

  localparam int DIR_ROWS = 16;
  localparam int WATCHDOG = 30000;

  arm_result_t pending_results[$];
  int          err_cnt;
  int          items_sent;
  int          stall_cnt;

  // predictor state: table, round bookkeeping, registers
  logic [SCORE_W-1:0]  tbl_score [MAX_ARMS];
  logic [LABEL_W-1:0]  tbl_label [MAX_ARMS];
  bit                  tbl_wr    [MAX_ARMS];
  logic [BUDGET_W-1:0] budget_left;
  logic [BUDGET_W-1:0] picks;
  logic [CNT_W-1:0]    active_n;
  logic [ROUND_W-1:0]  rounds_done;
  logic [CNT_W-1:0]    reg_arm_count;
  logic [BUDGET_W-1:0] reg_total_budget;

  function automatic int clamp_arms(input logic [CNT_W-1:0] c);
    int n;
    n = c;
    if (n < 2) n = 2;
    if (n > MAX_ARMS) n = MAX_ARMS;
    return n;
  endfunction

  // floor(total / ceil(log2 n)), at least one
  function automatic logic [BUDGET_W-1:0] round_budget();
    int n;
    int r;
    int b;
    n = clamp_arms(reg_arm_count);
    r = 0;
    while ((1 << r) < n) r++;
    b = reg_total_budget / r;
    return (b == 0) ? BUDGET_W'(1) : BUDGET_W'(b);
  endfunction

  // stable descending insertion sort of the active prefix
  task automatic sort_active_prefix();
    logic [SCORE_W-1:0] s;
    logic [LABEL_W-1:0] l;
    bit                 w;
    int                 j;
    for (int i = 1; i < active_n && i < MAX_ARMS; i++) begin
      s = tbl_score[i];
      l = tbl_label[i];
      w = tbl_wr[i];
      j = i;
      while (j > 0 && tbl_score[j-1] < s) begin
        tbl_score[j] = tbl_score[j-1];
        tbl_label[j] = tbl_label[j-1];
        tbl_wr[j]    = tbl_wr[j-1];
        j--;
      end
      tbl_score[j] = s;
      tbl_label[j] = l;
      tbl_wr[j]    = w;
    end
  endtask

  task automatic predict_arm_result(input req_t req, input logic [LABEL_W-1:0] id,
                                    input logic [SCORE_W-1:0] rew,
                                    output arm_result_t res);
    int idx;
    res.chosen = '0;
    case (req)
      REQ_LOAD: begin
        tbl_score[id] = rew;
        tbl_label[id] = id;
        tbl_wr[id]    = 1'b1;
        budget_left   = round_budget();
        picks         = '0;
        active_n      = CNT_W'(clamp_arms(reg_arm_count));
        rounds_done   = '0;
      end
      REQ_SELECT: begin
        if (budget_left == '0) begin
          // round boundary: sort, then keep the upper half
          budget_left = round_budget();
          if (rounds_done != ROUND_MAX) rounds_done++;
          picks = '0;
          sort_active_prefix();
          active_n = (active_n + 1) / 2;
          if (active_n == '0) active_n = 1;
        end
        idx = picks % active_n;
        if (idx >= MAX_ARMS) idx = 0;
        res.chosen  = tbl_label[idx];
        budget_left = budget_left - 1'b1;
        picks       = picks + 1'b1;
      end
      REQ_REPORT: begin
        // first active match only
        for (int i = 0; i < active_n && i < MAX_ARMS; i++) begin
          if (tbl_label[i] == id) begin
            tbl_score[i] = rew;
            break;
          end
        end
      end
      default: ;
    endcase
    res.best       = (tbl_score[0] > tbl_score[1]) ? tbl_label[0] : tbl_label[1];
    res.best_known = tbl_wr[0] && tbl_wr[1];
    res.rounds     = rounds_done;
  endtask

  // sender gap probability follows the run's progress
  function automatic int idle_pct();
    if (items_sent < 550) return 16;
    if (items_sent < 1100) return 49;
    return 0;
  endfunction

  // drive one transaction, hold until accepted; start stays high for back-to-back
  task automatic send_request(input req_t req, input logic [LABEL_W-1:0] id,
                              input logic [SCORE_W-1:0] rew, input bit typed,
                              input arm_result_t typed_res);
    arm_result_t res;
    if ($urandom_range(99) < idle_pct()) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct());
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_arm_id   <= id;
    in_reward   <= rew;
    predict_arm_result(req, id, rew, res);
    if (typed) begin
      typed_res.best_known = 1'b1;
      pending_results.insert(pending_results.size(), typed_res);
    end else begin
      pending_results.insert(pending_results.size(), res);
    end
    items_sent++;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_plain(input req_t req, input logic [LABEL_W-1:0] id,
                            input logic [SCORE_W-1:0] rew);
    arm_result_t none;
    none = '{default: '0};
    send_request(req, id, rew, 1'b0, none);
  endtask

  // let the block go idle before touching registers
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // write enable stays high; the caller drops it after the last write
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_ARM_COUNT) reg_arm_count = val[CNT_W-1:0];
    else reg_total_budget = val[BUDGET_W-1:0];
  endtask

  function automatic logic [SCORE_W-1:0] rand_reward();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  // mostly selects and reports of live arms, some loads and nops
  task automatic random_item();
    int                 k;
    logic [LABEL_W-1:0] id;
    k  = $urandom_range(99);
    id = LABEL_W'($urandom);
    if (k < 50) begin
      send_plain(REQ_SELECT, id, rand_reward());
    end else if (k < 78) begin
      if ($urandom_range(3) != 0) id = tbl_label[$urandom_range(active_n - 1)];
      send_plain(REQ_REPORT, id, rand_reward());
    end else if (k < 94) begin
      send_plain(REQ_LOAD, id, rand_reward());
    end else begin
      send_plain(REQ_NOP, id, rand_reward());
    end
  endtask

  // result checker: every strobe pairs with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result transaction chosen=%0d best=%0d round=%0d",
                                    out_chosen_arm, out_best_arm, out_round_number);
      end else begin
        arm_result_t e;
        e = pending_results.pop_front();
        if (out_chosen_arm !== e.chosen || out_round_number !== e.rounds ||
            (e.best_known && out_best_arm !== e.best)) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp chosen=%0d best=%0d round=%0d got chosen=%0d best=%0d round=%0d",
                     e.chosen, e.best, e.rounds, out_chosen_arm, out_best_arm,
                     out_round_number);
        end
      end
    end
  end

  // watchdog on cycles with no accepted transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  dir_row_t dir_tab [DIR_ROWS];
  int       ph_cnt [8] = '{2, 64, 64, 5, 127, 0, 33, 8};
  int       ph_bud [8] = '{1, 1048575, 7, 40, 100, 3, 0, 1000};
  int       ph_len [8] = '{150, 200, 200, 250, 250, 200, 200, 200};

  initial begin
    arm_result_t tr;
    err_cnt          = 0;
    items_sent       = 0;
    reg_arm_count    = 8;
    reg_total_budget = 1000;
    budget_left      = '0;
    picks            = '0;
    active_n         = 8;
    rounds_done      = '0;
    for (int i = 0; i < MAX_ARMS; i++) begin
      tbl_score[i] = '0;
      tbl_label[i] = '0;
      tbl_wr[i]    = 1'b0;
    end
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = REQ_NOP;
    in_arm_id   = '0;
    in_reward   = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_ARM_COUNT;
    cfg_wdata   = '0;

    // table after init: score = id*1000, n = 8, active 8, round budget 333
    dir_tab[0]  = '{REQ_NOP,    63, 16'hFFFF, 1, 0, 1, 0};
    dir_tab[1]  = '{REQ_SELECT, 0,  16'h0000, 1, 0, 1, 0};
    dir_tab[2]  = '{REQ_SELECT, 0,  16'h0000, 1, 1, 1, 0};
    dir_tab[3]  = '{REQ_REPORT, 0,  16'hFFFF, 1, 0, 0, 0};
    dir_tab[4]  = '{REQ_REPORT, 63, 16'h0000, 1, 0, 0, 0};  // not active: ignored
    dir_tab[5]  = '{REQ_LOAD,   1,  16'h0000, 1, 0, 0, 0};
    dir_tab[6]  = '{REQ_LOAD,   0,  16'h0000, 1, 0, 1, 0};  // tie goes to entry 1
    dir_tab[7]  = '{REQ_REPORT, 7,  16'hFFFF, 0, 0, 0, 0};
    dir_tab[8]  = '{REQ_SELECT, 0,  16'h0000, 0, 0, 0, 0};
    dir_tab[9]  = '{REQ_SELECT, 63, 16'hFFFF, 0, 0, 0, 0};
    dir_tab[10] = '{REQ_LOAD,   63, 16'hFFFF, 0, 0, 0, 0};
    dir_tab[11] = '{REQ_REPORT, 2,  16'h8000, 0, 0, 0, 0};
    dir_tab[12] = '{REQ_SELECT, 21, 16'h5555, 0, 0, 0, 0};
    dir_tab[13] = '{REQ_SELECT, 42, 16'hAAAA, 0, 0, 0, 0};
    dir_tab[14] = '{REQ_NOP,    0,  16'h0000, 0, 0, 0, 0};
    dir_tab[15] = '{REQ_SELECT, 0,  16'h0000, 0, 0, 0, 0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every entry so no unwritten entry is ever read
    for (int i = 0; i < MAX_ARMS; i++) send_plain(REQ_LOAD, LABEL_W'(i), SCORE_W'(i * 1000));

    for (int r = 0; r < DIR_ROWS; r++) begin
      tr.chosen = dir_tab[r].chosen;
      tr.best   = dir_tab[r].best;
      tr.rounds = dir_tab[r].rounds;
      send_request(dir_tab[r].req, dir_tab[r].id, dir_tab[r].rew, dir_tab[r].typed, tr);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      drain();
      write_reg(CFG_ARM_COUNT, CFG_W'(ph_cnt[p]));
      write_reg(CFG_TOTAL_BUDGET,
                (ph_bud[p] == 0) ? CFG_W'($urandom_range(1, 1048575)) : CFG_W'(ph_bud[p]));
      cfg_we <= 1'b0;
      // a select before the restart still runs with the old round state
      send_plain(REQ_SELECT, '0, '0);
      send_plain(REQ_LOAD, LABEL_W'($urandom), rand_reward());
      for (int k = 0; k < ph_len[p]; k++) random_item();
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
